/* hdl/lrc_pkg.sv */
package lrc_pkg;

  localparam int OCC_BITS  = 3;
  localparam int VIR_BITS  = 4;
  localparam int IDX_BITS  = 4;
  localparam int FUNC_BITS = 4;
  localparam int ELEM_BITS = 32;
  localparam int OP_BITS   = 34;
  localparam int ACC_BITS  = 128;
  localparam int OUT_BITS  = 64;

  localparam int OCC_CNT_BITS = 4;
  localparam int VIR_CNT_BITS = 5;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [OCC_CNT_BITS-1:0] MAX_OCCUPIED = 4'd8;
  localparam logic [VIR_CNT_BITS-1:0] MAX_VIRTUAL  = 5'd16;

  // Configuration register indexes.
  localparam logic CFG_OCCUPIED = 1'b0;
  localparam logic CFG_VIRTUAL  = 1'b1;

  // Function codes of an input beat.
  localparam logic [FUNC_BITS-1:0] TNS_PERT_VO    = 4'd0;
  localparam logic [FUNC_BITS-1:0] TNS_RESP_Y1    = 4'd1;
  localparam logic [FUNC_BITS-1:0] TNS_PERT_VVOO  = 4'd2;
  localparam logic [FUNC_BITS-1:0] TNS_RESP_Y2    = 4'd3;
  localparam logic [FUNC_BITS-1:0] TNS_LAMBDA_S   = 4'd4;
  localparam logic [FUNC_BITS-1:0] TNS_BARE_OV    = 4'd5;
  localparam logic [FUNC_BITS-1:0] TNS_RESP_X2    = 4'd6;
  localparam logic [FUNC_BITS-1:0] TNS_PERT_VV    = 4'd7;
  localparam logic [FUNC_BITS-1:0] TNS_RESP_X1    = 4'd8;
  localparam logic [FUNC_BITS-1:0] TNS_PERT_OO    = 4'd9;
  localparam logic [FUNC_BITS-1:0] TNS_LAMBDA_D   = 4'd10;
  localparam logic [FUNC_BITS-1:0] TNS_PERT_VVVO  = 4'd11;
  localparam logic [FUNC_BITS-1:0] TNS_PERT_OVOO  = 4'd12;
  localparam logic [FUNC_BITS-1:0] FUNC_START     = 4'd13;

  // One kind of contraction term for each loop nest; the sequencer walks them in order.
  typedef enum logic [3:0] {
    TERM_P1A,
    TERM_P1B,
    TERM_D,
    TERM_VV,
    TERM_OO,
    TERM_L3,
    TERM_OV1,
    TERM_OV2,
    TERM_X2O1,
    TERM_X2O2,
    TERM_X2V1,
    TERM_X2V2,
    TERM_OVX,
    TERM_END
  } term_e;

  typedef struct packed {
    logic                valid;
    term_e               kind;
    logic [OCC_BITS-1:0] i;
    logic [VIR_BITS-1:0] a;
    logic [OCC_BITS-1:0] j;
    logic [VIR_BITS-1:0] b;
    logic [VIR_BITS-1:0] e;
  } term_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] vo;
    logic [ELEM_BITS-1:0] y1;
    logic [ELEM_BITS-1:0] vvoo0;
    logic [ELEM_BITS-1:0] vvoo1;
    logic [ELEM_BITS-1:0] y2;
    logic [ELEM_BITS-1:0] l1;
    logic [ELEM_BITS-1:0] ov;
    logic [ELEM_BITS-1:0] x2a;
    logic [ELEM_BITS-1:0] x2b;
    logic [ELEM_BITS-1:0] vv;
    logic [ELEM_BITS-1:0] x1;
    logic [ELEM_BITS-1:0] oo;
    logic [ELEM_BITS-1:0] ld;
    logic [ELEM_BITS-1:0] vvvo;
    logic [ELEM_BITS-1:0] ovoo;
  } rd_t;

endpackage

/* hdl/lrc_store.sv */
module lrc_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [lrc_pkg::FUNC_BITS-1:0]       func_i,
  input  logic [lrc_pkg::IDX_BITS-1:0]        idx0_i,
  input  logic [lrc_pkg::IDX_BITS-1:0]        idx1_i,
  input  logic [lrc_pkg::IDX_BITS-1:0]        idx2_i,
  input  logic [lrc_pkg::IDX_BITS-1:0]        idx3_i,
  input  logic [lrc_pkg::ELEM_BITS-1:0]       wdata_i,
  input  lrc_pkg::term_t                      term_i,
  output lrc_pkg::term_t                      term_o,
  output lrc_pkg::rd_t                        rd_o
);

  localparam int OB = lrc_pkg::OCC_BITS;
  localparam int VB = lrc_pkg::VIR_BITS;
  localparam int EB = lrc_pkg::ELEM_BITS;
  localparam int AW_OV   = OB + VB;
  localparam int AW_VV   = 2 * VB;
  localparam int AW_OO   = 2 * OB;
  localparam int AW_OOVV = 2 * OB + 2 * VB;
  localparam int AW_VVVO = 3 * VB + OB;
  localparam int AW_OVOO = 3 * OB + VB;

  logic [EB-1:0] mem_vo   [2**AW_OV];
  logic [EB-1:0] mem_y1   [2**AW_OV];
  logic [EB-1:0] mem_vvoo [2**AW_OOVV];
  logic [EB-1:0] mem_y2   [2**AW_OOVV];
  logic [EB-1:0] mem_l1   [2**AW_OV];
  logic [EB-1:0] mem_ov   [2**AW_OV];
  logic [EB-1:0] mem_x2   [2**AW_OOVV];
  logic [EB-1:0] mem_vv   [2**AW_VV];
  logic [EB-1:0] mem_x1   [2**AW_OV];
  logic [EB-1:0] mem_oo   [2**AW_OO];
  logic [EB-1:0] mem_ld   [2**AW_OOVV];
  logic [EB-1:0] mem_vvvo [2**AW_VVVO];
  logic [EB-1:0] mem_ovoo [2**AW_OVOO];

  // An occupied index is in range when its bits above the occupied width are clear.
  logic ok0, ok1, ok2, ok3;
  assign ok0 = ~|idx0_i[lrc_pkg::IDX_BITS-1:OB];
  assign ok1 = ~|idx1_i[lrc_pkg::IDX_BITS-1:OB];
  assign ok2 = ~|idx2_i[lrc_pkg::IDX_BITS-1:OB];
  assign ok3 = ~|idx3_i[lrc_pkg::IDX_BITS-1:OB];

  logic [AW_OV-1:0]   wa_vo, wa_ov;
  logic [AW_OOVV-1:0] wa_vvoo, wa_oovv;
  logic [AW_VV-1:0]   wa_vv;
  logic [AW_OO-1:0]   wa_oo;
  logic [AW_VVVO-1:0] wa_vvvo;
  logic [AW_OVOO-1:0] wa_ovoo;

  assign wa_vo   = {idx0_i[VB-1:0], idx1_i[OB-1:0]};
  assign wa_ov   = {idx0_i[OB-1:0], idx1_i[VB-1:0]};
  assign wa_vvoo = {idx0_i[VB-1:0], idx1_i[VB-1:0], idx2_i[OB-1:0], idx3_i[OB-1:0]};
  assign wa_oovv = {idx0_i[OB-1:0], idx1_i[OB-1:0], idx2_i[VB-1:0], idx3_i[VB-1:0]};
  assign wa_vv   = {idx0_i[VB-1:0], idx1_i[VB-1:0]};
  assign wa_oo   = {idx0_i[OB-1:0], idx1_i[OB-1:0]};
  assign wa_vvvo = {idx0_i[VB-1:0], idx1_i[VB-1:0], idx2_i[VB-1:0], idx3_i[OB-1:0]};
  assign wa_ovoo = {idx0_i[OB-1:0], idx1_i[VB-1:0], idx2_i[OB-1:0], idx3_i[OB-1:0]};

  logic we_vo, we_y1, we_vvoo, we_y2, we_l1, we_ov, we_x2;
  logic we_vv, we_x1, we_oo, we_ld, we_vvvo, we_ovoo;

  assign we_vo   = load_i && (func_i == lrc_pkg::TNS_PERT_VO)   && ok1;
  assign we_y1   = load_i && (func_i == lrc_pkg::TNS_RESP_Y1)   && ok0;
  assign we_vvoo = load_i && (func_i == lrc_pkg::TNS_PERT_VVOO) && ok2 && ok3;
  assign we_y2   = load_i && (func_i == lrc_pkg::TNS_RESP_Y2)   && ok0 && ok1;
  assign we_l1   = load_i && (func_i == lrc_pkg::TNS_LAMBDA_S)  && ok0;
  assign we_ov   = load_i && (func_i == lrc_pkg::TNS_BARE_OV)   && ok0;
  assign we_x2   = load_i && (func_i == lrc_pkg::TNS_RESP_X2)   && ok0 && ok1;
  assign we_vv   = load_i && (func_i == lrc_pkg::TNS_PERT_VV);
  assign we_x1   = load_i && (func_i == lrc_pkg::TNS_RESP_X1)   && ok0;
  assign we_oo   = load_i && (func_i == lrc_pkg::TNS_PERT_OO)   && ok0 && ok1;
  assign we_ld   = load_i && (func_i == lrc_pkg::TNS_LAMBDA_D)  && ok0 && ok1;
  assign we_vvvo = load_i && (func_i == lrc_pkg::TNS_PERT_VVVO) && ok3;
  assign we_ovoo = load_i && (func_i == lrc_pkg::TNS_PERT_OVOO) && ok0 && ok2 && ok3;

  logic [OB-1:0] ti, tj, tk;
  logic [VB-1:0] ta, tb, te;
  assign ti = term_i.i;
  assign tj = term_i.j;
  assign ta = term_i.a;
  assign tb = term_i.b;
  assign te = term_i.e;
  assign tk = term_i.e[OB-1:0];

  logic [AW_OV-1:0]   ra_vo, ra_y1, ra_l1, ra_ov, ra_x1;
  logic [AW_OOVV-1:0] ra_vvoo0, ra_vvoo1, ra_y2, ra_x2a, ra_x2b, ra_ld;
  logic [AW_VV-1:0]   ra_vv;
  logic [AW_OO-1:0]   ra_oo;
  logic [AW_VVVO-1:0] ra_vvvo;
  logic [AW_OVOO-1:0] ra_ovoo;

  assign ra_vo    = {ta, ti};
  assign ra_y1    = {ti, ta};
  assign ra_vvoo0 = {ta, tb, ti, tj};
  assign ra_vvoo1 = {tb, ta, tj, ti};
  assign ra_y2    = {ti, tj, ta, tb};
  assign ra_l1    = {ti, ta};
  assign ra_x2b   = {ti, tj, tb, ta};
  assign ra_vvvo  = {tb, te, ta, tj};

  always_comb begin
    ra_ov   = {ti, ta};
    ra_x2a  = {ti, tj, ta, tb};
    ra_vv   = {ta, te};
    ra_x1   = {ti, ta};
    ra_oo   = {tk, ti};
    ra_ld   = {ti, tj, ta, tb};
    ra_ovoo = {tk, tb, ti, tj};
    case (term_i.kind)
      lrc_pkg::TERM_D: begin
        ra_ov = {tj, tb};
      end
      lrc_pkg::TERM_VV: begin
        ra_x1 = {ti, te};
      end
      lrc_pkg::TERM_OO: begin
        ra_x1 = {tk, ta};
      end
      lrc_pkg::TERM_L3: begin
        ra_ld = {ti, tj, tb, te};
      end
      lrc_pkg::TERM_OV1: begin
        ra_x1 = {tk, ta};
      end
      lrc_pkg::TERM_OV2: begin
        ra_x1   = {tk, tb};
        ra_ovoo = {tk, ta, tj, ti};
      end
      lrc_pkg::TERM_X2O1: begin
        ra_x2a = {tk, tj, ta, tb};
      end
      lrc_pkg::TERM_X2O2: begin
        ra_x2a = {tk, ti, tb, ta};
        ra_oo  = {tk, tj};
      end
      lrc_pkg::TERM_X2V1: begin
        ra_x2a = {ti, tj, ta, te};
        ra_vv  = {tb, te};
      end
      lrc_pkg::TERM_X2V2: begin
        ra_x2a = {tj, ti, tb, te};
      end
      default: begin
      end
    endcase
  end

  logic [EB-1:0] rd_vo, rd_y1, rd_vvoo0, rd_vvoo1, rd_y2, rd_l1, rd_ov, rd_x2a, rd_x2b;
  logic [EB-1:0] rd_vv, rd_x1, rd_oo, rd_ld, rd_vvvo, rd_ovoo;

  always_ff @(posedge clk_i) begin
    if (we_vo) mem_vo[wa_vo] <= wdata_i;
    rd_vo <= mem_vo[ra_vo];
  end

  always_ff @(posedge clk_i) begin
    if (we_y1) mem_y1[wa_ov] <= wdata_i;
    rd_y1 <= mem_y1[ra_y1];
  end

  always_ff @(posedge clk_i) begin
    if (we_vvoo) mem_vvoo[wa_vvoo] <= wdata_i;
    rd_vvoo0 <= mem_vvoo[ra_vvoo0];
    rd_vvoo1 <= mem_vvoo[ra_vvoo1];
  end

  always_ff @(posedge clk_i) begin
    if (we_y2) mem_y2[wa_oovv] <= wdata_i;
    rd_y2 <= mem_y2[ra_y2];
  end

  always_ff @(posedge clk_i) begin
    if (we_l1) mem_l1[wa_ov] <= wdata_i;
    rd_l1 <= mem_l1[ra_l1];
  end

  always_ff @(posedge clk_i) begin
    if (we_ov) mem_ov[wa_ov] <= wdata_i;
    rd_ov <= mem_ov[ra_ov];
  end

  always_ff @(posedge clk_i) begin
    if (we_x2) mem_x2[wa_oovv] <= wdata_i;
    rd_x2a <= mem_x2[ra_x2a];
    rd_x2b <= mem_x2[ra_x2b];
  end

  always_ff @(posedge clk_i) begin
    if (we_vv) mem_vv[wa_vv] <= wdata_i;
    rd_vv <= mem_vv[ra_vv];
  end

  always_ff @(posedge clk_i) begin
    if (we_x1) mem_x1[wa_ov] <= wdata_i;
    rd_x1 <= mem_x1[ra_x1];
  end

  always_ff @(posedge clk_i) begin
    if (we_oo) mem_oo[wa_oo] <= wdata_i;
    rd_oo <= mem_oo[ra_oo];
  end

  always_ff @(posedge clk_i) begin
    if (we_ld) mem_ld[wa_oovv] <= wdata_i;
    rd_ld <= mem_ld[ra_ld];
  end

  always_ff @(posedge clk_i) begin
    if (we_vvvo) mem_vvvo[wa_vvvo] <= wdata_i;
    rd_vvvo <= mem_vvvo[ra_vvvo];
  end

  always_ff @(posedge clk_i) begin
    if (we_ovoo) mem_ovoo[wa_ovoo] <= wdata_i;
    rd_ovoo <= mem_ovoo[ra_ovoo];
  end

  // The term travels alongside its read data.
  lrc_pkg::term_t term_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
    end else begin
      term_q <= term_i;
    end
  end

  assign term_o   = term_q;
  assign rd_o.vo    = rd_vo;
  assign rd_o.y1    = rd_y1;
  assign rd_o.vvoo0 = rd_vvoo0;
  assign rd_o.vvoo1 = rd_vvoo1;
  assign rd_o.y2    = rd_y2;
  assign rd_o.l1    = rd_l1;
  assign rd_o.ov    = rd_ov;
  assign rd_o.x2a   = rd_x2a;
  assign rd_o.x2b   = rd_x2b;
  assign rd_o.vv    = rd_vv;
  assign rd_o.x1    = rd_x1;
  assign rd_o.oo    = rd_oo;
  assign rd_o.ld    = rd_ld;
  assign rd_o.vvvo  = rd_vvvo;
  assign rd_o.ovoo  = rd_ovoo;

endmodule

/* hdl/lrc_seq.sv */
module lrc_seq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [lrc_pkg::OCC_CNT_BITS-1:0]     occ_i,
  input  logic [lrc_pkg::VIR_CNT_BITS-1:0]     vir_i,
  output lrc_pkg::term_t                       term_o
);

  localparam int OB = lrc_pkg::OCC_BITS;
  localparam int VB = lrc_pkg::VIR_BITS;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e                state_q;
  lrc_pkg::term_e        kind_q;
  logic [OB-1:0]         i_q, j_q, no_m1_q;
  logic [VB-1:0]         a_q, b_q, e_q, nv_m1_q;
  lrc_pkg::term_t        term_q;

  logic use_j, use_b, use_e, e_vir;

  always_comb begin
    use_j = 1'b0;
    use_b = 1'b0;
    use_e = 1'b0;
    e_vir = 1'b0;
    case (kind_q)
      lrc_pkg::TERM_P1B, lrc_pkg::TERM_D: begin
        use_j = 1'b1;
        use_b = 1'b1;
      end
      lrc_pkg::TERM_VV: begin
        use_e = 1'b1;
        e_vir = 1'b1;
      end
      lrc_pkg::TERM_OO: begin
        use_e = 1'b1;
      end
      lrc_pkg::TERM_L3, lrc_pkg::TERM_X2V1, lrc_pkg::TERM_X2V2: begin
        use_j = 1'b1;
        use_b = 1'b1;
        use_e = 1'b1;
        e_vir = 1'b1;
      end
      lrc_pkg::TERM_OV1, lrc_pkg::TERM_OV2, lrc_pkg::TERM_X2O1, lrc_pkg::TERM_X2O2: begin
        use_j = 1'b1;
        use_b = 1'b1;
        use_e = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic last_i, last_a, last_j, last_b, last_e;
  assign last_i = (i_q == no_m1_q);
  assign last_a = (a_q == nv_m1_q);
  assign last_j = !use_j || (j_q == no_m1_q);
  assign last_b = !use_b || (b_q == nv_m1_q);
  assign last_e = !use_e || (e_vir ? (e_q == nv_m1_q) : (e_q == {1'b0, no_m1_q}));

  logic [lrc_pkg::OCC_CNT_BITS-1:0] occ_cl;
  logic [lrc_pkg::VIR_CNT_BITS-1:0] vir_cl;
  logic [lrc_pkg::OCC_CNT_BITS-1:0] occ_m1;
  logic [lrc_pkg::VIR_CNT_BITS-1:0] vir_m1;
  assign occ_cl = (occ_i > lrc_pkg::MAX_OCCUPIED) ? lrc_pkg::MAX_OCCUPIED : occ_i;
  assign vir_cl = (vir_i > lrc_pkg::MAX_VIRTUAL) ? lrc_pkg::MAX_VIRTUAL : vir_i;
  assign occ_m1 = occ_cl - 4'd1;
  assign vir_m1 = vir_cl - 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= lrc_pkg::TERM_P1A;
      i_q     <= '0;
      j_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      e_q     <= '0;
      no_m1_q <= '0;
      nv_m1_q <= '0;
      term_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          term_q.valid <= 1'b0;
          if (start_i) begin
            no_m1_q <= occ_m1[OB-1:0];
            nv_m1_q <= vir_m1[VB-1:0];
            i_q     <= '0;
            j_q     <= '0;
            a_q     <= '0;
            b_q     <= '0;
            e_q     <= '0;
            // An empty orbital range leaves every nest empty.
            if ((occ_cl == '0) || (vir_cl == '0)) begin
              kind_q <= lrc_pkg::TERM_END;
            end else begin
              kind_q <= lrc_pkg::TERM_P1A;
            end
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          term_q.valid <= 1'b1;
          term_q.kind  <= kind_q;
          term_q.i     <= i_q;
          term_q.a     <= a_q;
          term_q.j     <= j_q;
          term_q.b     <= b_q;
          term_q.e     <= e_q;
          if (kind_q == lrc_pkg::TERM_END) begin
            state_q <= S_IDLE;
          end else if (!last_e) begin
            e_q <= e_q + 1'b1;
          end else begin
            e_q <= '0;
            if (!last_b) begin
              b_q <= b_q + 1'b1;
            end else begin
              b_q <= '0;
              if (!last_j) begin
                j_q <= j_q + 1'b1;
              end else begin
                j_q <= '0;
                if (!last_a) begin
                  a_q <= a_q + 1'b1;
                end else begin
                  a_q <= '0;
                  if (!last_i) begin
                    i_q <= i_q + 1'b1;
                  end else begin
                    i_q    <= '0;
                    kind_q <= lrc_pkg::term_e'(4'(kind_q) + 4'd1);
                  end
                end
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign term_o = term_q;

endmodule

/* hdl/lrc_mac.sv */
module lrc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               take_i,
  input  lrc_pkg::term_t                     term_i,
  input  lrc_pkg::rd_t                       rd_i,
  output logic                               res_valid_o,
  output logic [lrc_pkg::OUT_BITS-1:0]       first_o,
  output logic [lrc_pkg::OUT_BITS-1:0]       second_o,
  output logic [lrc_pkg::OUT_BITS-1:0]       total_o
);

  localparam int OPB = lrc_pkg::OP_BITS;
  localparam int AB  = lrc_pkg::ACC_BITS;
  localparam int OB  = lrc_pkg::OUT_BITS;
  localparam int PB  = 2 * OPB;
  localparam int LB  = 2 * OPB + 1;
  localparam int ROUND_SHIFT = 37;
  localparam logic signed [OPB-1:0] ONE = 34'sd268435456;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       sel2;
    logic       neg;
    logic [1:0] shift;
  } ctl_t;

  function automatic logic signed [OPB-1:0] ext(input logic [lrc_pkg::ELEM_BITS-1:0] v);
    return $signed({{(OPB - lrc_pkg::ELEM_BITS){v[lrc_pkg::ELEM_BITS-1]}}, v});
  endfunction

  // Round to nearest with ties upward, then saturate to the output width.
  function automatic logic [OB-1:0] round_sat(input logic signed [AB-1:0] v);
    logic signed [AB-1:0] r;
    logic signed [AB-1:0] bias;
    bias = '0;
    bias[ROUND_SHIFT-1] = 1'b1;
    r = (v + bias) >>> ROUND_SHIFT;
    if ((&r[AB-1:OB-1]) || !(|r[AB-1:OB-1])) begin
      return r[OB-1:0];
    end else if (r[AB-1]) begin
      return {1'b1, {(OB-1){1'b0}}};
    end else begin
      return {1'b0, {(OB-1){1'b1}}};
    end
  endfunction

  logic signed [OPB-1:0] x_d, y_d, z_d;
  ctl_t                  ctl_d;

  always_comb begin
    x_d = '0;
    y_d = '0;
    z_d = '0;
    ctl_d.valid = term_i.valid && (term_i.kind != lrc_pkg::TERM_END);
    ctl_d.last  = term_i.valid && (term_i.kind == lrc_pkg::TERM_END);
    ctl_d.sel2  = 1'b1;
    ctl_d.neg   = 1'b0;
    ctl_d.shift = 2'd0;
    case (term_i.kind)
      lrc_pkg::TERM_P1A: begin
        x_d = ext(rd_i.vo);
        y_d = ext(rd_i.y1);
        z_d = ONE;
        ctl_d.sel2  = 1'b0;
        ctl_d.shift = 2'd1;
      end
      lrc_pkg::TERM_P1B: begin
        x_d = ext(rd_i.vvoo0) + ext(rd_i.vvoo1);
        y_d = ext(rd_i.y2);
        z_d = ONE;
        ctl_d.sel2 = 1'b0;
      end
      lrc_pkg::TERM_D: begin
        x_d = ext(rd_i.l1);
        y_d = ext(rd_i.ov);
        z_d = (ext(rd_i.x2a) <<< 1) - ext(rd_i.x2b);
        ctl_d.shift = 2'd1;
      end
      lrc_pkg::TERM_VV: begin
        x_d = ext(rd_i.l1);
        y_d = ext(rd_i.vv);
        z_d = ext(rd_i.x1);
        ctl_d.shift = 2'd1;
      end
      lrc_pkg::TERM_OO: begin
        x_d = ext(rd_i.l1);
        y_d = ext(rd_i.oo);
        z_d = ext(rd_i.x1);
        ctl_d.shift = 2'd1;
        ctl_d.neg   = 1'b1;
      end
      lrc_pkg::TERM_L3: begin
        x_d = ext(rd_i.ld);
        y_d = ext(rd_i.x1);
        z_d = ext(rd_i.vvvo);
        ctl_d.shift = 2'd1;
      end
      lrc_pkg::TERM_OV1, lrc_pkg::TERM_OV2: begin
        x_d = ext(rd_i.ld);
        y_d = ext(rd_i.x1);
        z_d = ext(rd_i.ovoo);
        ctl_d.neg = 1'b1;
      end
      lrc_pkg::TERM_X2O1, lrc_pkg::TERM_X2O2: begin
        x_d = ext(rd_i.ld);
        y_d = ext(rd_i.x2a);
        z_d = ext(rd_i.oo);
        ctl_d.neg = 1'b1;
      end
      lrc_pkg::TERM_X2V1, lrc_pkg::TERM_X2V2: begin
        x_d = ext(rd_i.ld);
        y_d = ext(rd_i.x2a);
        z_d = ext(rd_i.vv);
      end
      lrc_pkg::TERM_OVX: begin
        x_d = ext(rd_i.ov);
        y_d = ext(rd_i.x1);
        z_d = ONE;
        ctl_d.shift = 2'd2;
      end
      default: begin
      end
    endcase
  end

  // Product pipeline: x*y, then the 68-bit partial times z split into a low and a high half.
  logic signed [OPB-1:0] x_q, y_q, z_q, z1_q, z2_q, phi_q;
  logic signed [PB-1:0]  p_q, phh_q;
  logic signed [LB-1:0]  plo_q, plo2_q;
  logic signed [AB-1:0]  sum_q;
  ctl_t                  ctl_f_q, ctl_1_q, ctl_2_q, ctl_3_q, ctl_c_q;

  logic signed [PB-1:0]  p_d, phh_d;
  logic signed [LB-1:0]  plo_d;
  logic signed [OPB:0]   lo_s;
  logic signed [AB-1:0]  sum_d;

  assign p_d   = x_q * y_q;
  assign lo_s  = $signed({1'b0, p_q[OPB-1:0]});
  assign plo_d = lo_s * z1_q;
  assign phh_d = phi_q * z2_q;
  assign sum_d = $signed({{(AB - PB - OPB){phh_q[PB-1]}}, phh_q, {OPB{1'b0}}})
               + $signed({{(AB - LB){plo2_q[LB-1]}}, plo2_q});

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    p_q    <= p_d;
    z1_q   <= z_q;
    plo_q  <= plo_d;
    phi_q  <= p_q[PB-1:OPB];
    z2_q   <= z1_q;
    phh_q  <= phh_d;
    plo2_q <= plo_q;
    sum_q  <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_f_q <= '0;
      ctl_1_q <= '0;
      ctl_2_q <= '0;
      ctl_3_q <= '0;
      ctl_c_q <= '0;
    end else begin
      ctl_f_q <= ctl_d;
      ctl_1_q <= ctl_f_q;
      ctl_2_q <= ctl_1_q;
      ctl_3_q <= ctl_2_q;
      ctl_c_q <= ctl_3_q;
    end
  end

  logic signed [AB-1:0] term_v;
  always_comb begin
    case (ctl_c_q.shift)
      2'd1:    term_v = sum_q <<< 1;
      2'd2:    term_v = sum_q <<< 2;
      default: term_v = sum_q;
    endcase
  end

  logic signed [AB-1:0] acc1_q, acc2_q, nsum_q;
  logic                 fin_q, res_valid_q;
  logic [OB-1:0]        first_q, second_q, total_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc1_q <= '0;
      acc2_q <= '0;
    end else if (ctl_c_q.valid) begin
      if (ctl_c_q.sel2) begin
        acc2_q <= ctl_c_q.neg ? (acc2_q - term_v) : (acc2_q + term_v);
      end else begin
        acc1_q <= ctl_c_q.neg ? (acc1_q - term_v) : (acc1_q + term_v);
      end
    end
    if (ctl_c_q.last) begin
      nsum_q <= -(acc1_q + acc2_q);
    end
    if (fin_q) begin
      first_q  <= round_sat(acc1_q);
      second_q <= round_sat(acc2_q);
      total_q  <= round_sat(nsum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      fin_q <= ctl_c_q.last;
      if (take_i) begin
        res_valid_q <= 1'b0;
      end
      if (fin_q) begin
        res_valid_q <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign first_o     = first_q;
  assign second_o    = second_q;
  assign total_o     = total_q;

endmodule

/* hdl/cc_linear_response_contraction.sv */
// Linear-response polarizability contraction. Each input beat with tuser 0..12 writes one
// element (signed Q4.28) of one of thirteen tensors held in on-chip RAM, one beat per cycle
// while not busy; an element whose occupied index is out of range is dropped, and unwritten
// entries read as unknown. A beat with tuser 13 starts the contraction: a sequencer walks every
// loop nest and issues one triple-product term per cycle into the RAM read ports, T terms in
// all, where with no and nv the occupied and virtual orbitals in use
// T = 2*no*nv + no*nv^2 + no^2*nv + 2*no^2*nv^2 + 3*no^2*nv^3 + 4*no^3*nv^2.
// The term products run through a pipeline of 34-bit multipliers into two exact
// 128-bit accumulators. The result beat carries both terms and their negated sum, rounded to
// signed Q17.47 and saturated. The input stays not ready from the start beat until its result
// has moved into the output register. The orbital counts are sampled when a start beat is
// taken, so configuration writes belong between contractions.
module cc_linear_response_contraction (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [4:0]    cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // index_first[3:0], index_second[7:4], index_third[11:8], index_fourth[15:12],
  // element_value[47:16]
  input  logic [47:0]   s_axis_tdata,
  // func[3:0]
  input  logic [3:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // first_term[63:0], second_term[127:64], response_value[191:128]
  output logic [191:0]  m_axis_tdata
);

  localparam int OB = lrc_pkg::OUT_BITS;

  // Configuration registers.
  logic [lrc_pkg::OCC_CNT_BITS-1:0] occ_q;
  logic [lrc_pkg::VIR_CNT_BITS-1:0] vir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= lrc_pkg::MAX_OCCUPIED;
      vir_q <= lrc_pkg::MAX_VIRTUAL;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lrc_pkg::CFG_OCCUPIED) begin
        occ_q <= cfg_data_i[lrc_pkg::OCC_CNT_BITS-1:0];
      end else begin
        vir_q <= cfg_data_i;
      end
    end
  end

  // Input side: loads go straight into the RAMs; a start beat makes the block busy.
  logic busy_q;
  logic accept, load, start;

  assign s_axis_tready = !busy_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign load   = accept && (s_axis_tuser < lrc_pkg::FUNC_START);
  assign start  = accept && (s_axis_tuser == lrc_pkg::FUNC_START);

  lrc_pkg::term_t seq_term, rd_term;
  lrc_pkg::rd_t   rd_data;

  lrc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .occ_i   (occ_q),
    .vir_i   (vir_q),
    .term_o  (seq_term)
  );

  lrc_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .func_i  (s_axis_tuser),
    .idx0_i  (s_axis_tdata[3:0]),
    .idx1_i  (s_axis_tdata[7:4]),
    .idx2_i  (s_axis_tdata[11:8]),
    .idx3_i  (s_axis_tdata[15:12]),
    .wdata_i (s_axis_tdata[47:16]),
    .term_i  (seq_term),
    .term_o  (rd_term),
    .rd_o    (rd_data)
  );

  logic          res_valid, take;
  logic [OB-1:0] res_first, res_second, res_total;

  lrc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .take_i      (take),
    .term_i      (rd_term),
    .rd_i        (rd_data),
    .res_valid_o (res_valid),
    .first_o     (res_first),
    .second_o    (res_second),
    .total_o     (res_total)
  );

  // Output register: the result moves in once the previous beat has left.
  logic         m_valid_q;
  logic [191:0] m_data_q;

  assign take = res_valid && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      if (start) begin
        busy_q <= 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      m_data_q <= {res_total, res_second, res_first};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
